@@ hdl/ptf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_pkg
// shared types and constants of the infix to postfix tokenizer
// ----------------------------------------------------------------------------
package ptf_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int MAX_NUMBERS = 26;

    // stack pointer holds 0..STACK_DEPTH, stack index 0..STACK_DEPTH-1
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_NUMBERS + 1);

    localparam int VAL_W = 31;
    localparam logic [VAL_W-1:0] SAT_MAX = {VAL_W{1'b1}};

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;

    // stack entry codes
    typedef enum logic [2:0] {
        CODE_PLUS  = 3'd0,
        CODE_MINUS = 3'd1,
        CODE_TIMES = 3'd2,
        CODE_DIV   = 3'd3,
        CODE_PAREN = 3'd4
    } code_t;

    typedef enum logic [2:0] {
        KIND_NUM = 3'd0,
        KIND_LET = 3'd1,
        KIND_OP  = 3'd2,
        KIND_END = 3'd3,
        KIND_ERR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_CHAR = 3'd1,
        ERR_PARENS   = 3'd2,
        ERR_OVERFLOW = 3'd3,
        ERR_NUMBERS  = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_WAIT,
        ST_FIN,
        ST_FIN_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [4:0]       symbol;
        logic [VAL_W-1:0] value;
        logic [2:0]       err;
    } result_t;

    // control from sequencer to output stage
    typedef struct packed {
        logic    push;
        logic    run_last;
        result_t res;
    } out_push_t;

endpackage

@@ hdl/ptf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_if
// valid/ready channels for characters in and tokens out
// ----------------------------------------------------------------------------
interface ptf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface ptf_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [4:0]  symbol;
    logic [30:0] number_value;
    logic [2:0]  error_code;
    logic        run_last;

    modport source (output valid, output kind, output symbol, output number_value,
                    output error_code, output run_last, input ready);
    modport sink   (input valid, input kind, input symbol, input number_value,
                    input error_code, input run_last, output ready);
endinterface

@@ hdl/ptf_stack_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_stack_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ptf_stack_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 3,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/ptf_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_out_stage
// output register that drives the token channel
// ----------------------------------------------------------------------------
module ptf_out_stage import ptf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  out_push_t   push_in,
    output logic        out_free,
    ptf_token_if.source tokens
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    run_last_reg;

    assign out_free = !valid_reg || tokens.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_in.push)
        begin
            valid_next = 1'b1;
        end
        else if (tokens.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push)
        begin
            res_reg      <= push_in.res;
            run_last_reg <= push_in.run_last;
        end
    end

    assign tokens.valid        = valid_reg;
    assign tokens.kind         = res_reg.kind;
    assign tokens.symbol       = res_reg.symbol;
    assign tokens.number_value = res_reg.value;
    assign tokens.error_code   = res_reg.err;
    assign tokens.run_last     = run_last_reg;

endmodule

@@ hdl/ptf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_ctrl
// character sequencer: digit gathering, stack push and pop, expression finish
// ----------------------------------------------------------------------------
module ptf_ctrl import ptf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    ptf_char_if.sink         chars,
    input  logic             out_free,
    output out_push_t        push_out,
    output logic             ram_wr_en,
    output logic [IDX_W-1:0] ram_wr_addr,
    output logic [2:0]       ram_wr_data,
    output logic             ram_rd_en,
    output logic [IDX_W-1:0] ram_rd_addr,
    input  logic [2:0]       ram_rd_data
);

    state_t           state_reg, state_next;
    logic [7:0]       ch_reg, ch_next;
    logic             last_reg, last_next;
    logic [SP_W-1:0]  stack_count_reg, stack_count_next;
    logic [SP_W-1:0]  paren_count_reg, paren_count_next;
    logic [VAL_W-1:0] accum_reg, accum_next;
    logic             in_number_reg, in_number_next;
    logic [CNT_W-1:0] number_count_reg, number_count_next;
    logic             error_seen_reg, error_seen_next;
    logic             hold_valid_reg, hold_valid_next;
    result_t          hold_reg, hold_next;

    logic             is_digit, is_letter, is_op, is_open, is_close;
    logic [3:0]       digit;
    logic [34:0]      acc_x10;
    logic [VAL_W-1:0] acc_sat;
    code_t            push_code;
    logic             emit, emit_ok, err_req, clear;
    result_t          emit_res;
    err_t             err_code;
    logic             stack_full;

    assign is_digit  = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_letter = (ch_reg >= CH_UPPER_A) && (ch_reg <= CH_UPPER_Z);
    assign is_open   = (ch_reg == CH_OPEN);
    assign is_close  = (ch_reg == CH_CLOSE);
    assign is_op     = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS)
                    || (ch_reg == CH_STAR) || (ch_reg == CH_SLASH);
    assign digit     = 4'(ch_reg - CH_ZERO);
    assign stack_full = (stack_count_reg == SP_W'(STACK_DEPTH));

    // accum * 10 + digit, saturated
    assign acc_x10 = 35'({accum_reg, 3'b000}) + 35'({accum_reg, 1'b0}) + 35'(digit);
    assign acc_sat = (acc_x10 > 35'(SAT_MAX)) ? SAT_MAX : acc_x10[VAL_W-1:0];

    always_comb
    begin
        unique case (ch_reg)
            CH_PLUS:  push_code = CODE_PLUS;
            CH_MINUS: push_code = CODE_MINUS;
            CH_STAR:  push_code = CODE_TIMES;
            CH_SLASH: push_code = CODE_DIV;
            default:  push_code = CODE_PAREN;
        endcase
    end

    // a new result may enter the hold slot when the slot can drain
    assign emit_ok = !hold_valid_reg || out_free;

    always_comb
    begin
        state_next        = state_reg;
        ch_next           = ch_reg;
        last_next         = last_reg;
        stack_count_next  = stack_count_reg;
        paren_count_next  = paren_count_reg;
        accum_next        = accum_reg;
        in_number_next    = in_number_reg;
        number_count_next = number_count_reg;
        error_seen_next   = error_seen_reg;
        hold_valid_next   = hold_valid_reg;
        hold_next         = hold_reg;
        emit              = 1'b0;
        emit_res          = '0;
        err_req           = 1'b0;
        err_code          = ERR_NONE;
        clear             = 1'b0;
        push_out          = '0;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = stack_count_reg[IDX_W-1:0];
        ram_wr_data       = push_code;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = IDX_W'(stack_count_reg - SP_W'(1));
        chars.ready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (chars.valid)
                begin
                    ch_next    = chars.ch;
                    last_next  = chars.last_char;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                if (error_seen_reg)
                begin
                    clear      = last_reg;
                    state_next = ST_DONE;
                end
                else if (is_digit)
                begin
                    if (in_number_reg)
                    begin
                        accum_next = acc_sat;
                        state_next = last_reg ? ST_FIN : ST_DONE;
                    end
                    else if (number_count_reg >= CNT_W'(MAX_NUMBERS))
                    begin
                        err_req  = 1'b1;
                        err_code = ERR_NUMBERS;
                    end
                    else
                    begin
                        in_number_next = 1'b1;
                        accum_next     = VAL_W'(digit);
                        state_next     = last_reg ? ST_FIN : ST_DONE;
                    end
                end
                else if (in_number_reg)
                begin
                    // close the open digit run, then look at the char again
                    emit            = 1'b1;
                    emit_res.kind   = KIND_NUM;
                    emit_res.symbol = 5'(number_count_reg);
                    emit_res.value  = accum_reg;
                    if (emit_ok)
                    begin
                        number_count_next = number_count_reg + CNT_W'(1);
                        in_number_next    = 1'b0;
                        accum_next        = '0;
                    end
                end
                else if (is_letter)
                begin
                    emit            = 1'b1;
                    emit_res.kind   = KIND_LET;
                    emit_res.symbol = 5'(ch_reg - CH_UPPER_A);
                    if (emit_ok)
                    begin
                        state_next = last_reg ? ST_FIN : ST_DONE;
                    end
                end
                else if (is_op || is_open)
                begin
                    if (stack_full)
                    begin
                        err_req  = 1'b1;
                        err_code = ERR_OVERFLOW;
                    end
                    else
                    begin
                        ram_wr_en        = 1'b1;
                        stack_count_next = stack_count_reg + SP_W'(1);
                        if (is_open)
                        begin
                            paren_count_next = paren_count_reg + SP_W'(1);
                        end
                        state_next = last_reg ? ST_FIN : ST_DONE;
                    end
                end
                else if (is_close)
                begin
                    if (stack_count_reg == '0)
                    begin
                        err_req  = 1'b1;
                        err_code = ERR_PARENS;
                    end
                    else
                    begin
                        ram_rd_en        = 1'b1;
                        stack_count_next = stack_count_reg - SP_W'(1);
                        state_next       = ST_POP_WAIT;
                    end
                end
                else
                begin
                    err_req  = 1'b1;
                    err_code = ERR_BAD_CHAR;
                end
            end

            ST_POP_WAIT:
            begin
                if (ram_rd_data == CODE_PAREN)
                begin
                    paren_count_next = paren_count_reg - SP_W'(1);
                    state_next       = last_reg ? ST_FIN : ST_DONE;
                end
                else
                begin
                    emit            = 1'b1;
                    emit_res.kind   = KIND_OP;
                    emit_res.symbol = 5'(ram_rd_data);
                    if (emit_ok)
                    begin
                        state_next = ST_DECODE;
                    end
                end
            end

            ST_FIN:
            begin
                if (in_number_reg)
                begin
                    emit            = 1'b1;
                    emit_res.kind   = KIND_NUM;
                    emit_res.symbol = 5'(number_count_reg);
                    emit_res.value  = accum_reg;
                    if (emit_ok)
                    begin
                        number_count_next = number_count_reg + CNT_W'(1);
                        in_number_next    = 1'b0;
                        accum_next        = '0;
                    end
                end
                else if (paren_count_reg != '0)
                begin
                    err_req  = 1'b1;
                    err_code = ERR_PARENS;
                end
                else if (stack_count_reg == '0)
                begin
                    emit          = 1'b1;
                    emit_res.kind = KIND_END;
                    if (emit_ok)
                    begin
                        clear      = 1'b1;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    ram_rd_en        = 1'b1;
                    stack_count_next = stack_count_reg - SP_W'(1);
                    state_next       = ST_FIN_WAIT;
                end
            end

            ST_FIN_WAIT:
            begin
                emit            = 1'b1;
                emit_res.kind   = KIND_OP;
                emit_res.symbol = 5'(ram_rd_data);
                if (emit_ok)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_DONE:
            begin
                // release the held result as the final one of this char
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push_out.push     = 1'b1;
                    push_out.run_last = 1'b1;
                    push_out.res      = hold_reg;
                    hold_valid_next   = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (err_req)
        begin
            emit          = 1'b1;
            emit_res      = '0;
            emit_res.kind = KIND_ERR;
            emit_res.err  = err_code;
            if (emit_ok)
            begin
                error_seen_next = 1'b1;
                clear           = last_reg;
                state_next      = ST_DONE;
            end
        end

        if (emit && emit_ok)
        begin
            if (hold_valid_reg)
            begin
                push_out.push     = 1'b1;
                push_out.run_last = 1'b0;
                push_out.res      = hold_reg;
            end
            hold_next       = emit_res;
            hold_valid_next = 1'b1;
        end

        if (clear)
        begin
            stack_count_next  = '0;
            paren_count_next  = '0;
            accum_next        = '0;
            in_number_next    = 1'b0;
            number_count_next = '0;
            error_seen_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stack_count_reg  <= '0;
            paren_count_reg  <= '0;
            accum_reg        <= '0;
            in_number_reg    <= 1'b0;
            number_count_reg <= '0;
            error_seen_reg   <= 1'b0;
            hold_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stack_count_reg  <= stack_count_next;
            paren_count_reg  <= paren_count_next;
            accum_reg        <= accum_next;
            in_number_reg    <= in_number_next;
            number_count_reg <= number_count_next;
            error_seen_reg   <= error_seen_next;
            hold_valid_reg   <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        last_reg <= last_next;
        hold_reg <= hold_next;
    end

endmodule

@@ hdl/paren_infix_to_postfix_tokenizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paren_infix_to_postfix_tokenizer_top
// infix characters in, postfix tokens out; operator stack kept in a ram
// ----------------------------------------------------------------------------
// a char's token passes through ch_reg, the hold slot and the output register in turn
// a stalled token channel holds the sequencer; chars are taken one at a time
// reset: rst_n async low clears counters and flags; stack ram is not cleared,
//   entries at and above the stack pointer are never read
module paren_infix_to_postfix_tokenizer_top import ptf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ptf_char_if.sink    chars,
    ptf_token_if.source tokens
);

    // sequencer to output stage handshake
    out_push_t        push;
    logic             out_free;

    // operator stack ram port
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [2:0]       ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [2:0]       ram_rd_data;

    // sequencer: decodes each char, drives pushes and pops, keeps one
    // token in hold so the last token of a char can be flagged run_last
    ptf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .out_free    (out_free),
        .push_out    (push),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // operator stack: push and pop never fall in the same cycle, so a read
    // always sees the latest write without forwarding
    ptf_stack_ram #(
        .DEPTH  (STACK_DEPTH),
        .WIDTH  (3),
        .ADDR_W (IDX_W)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register toward the token consumer
    ptf_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_in  (push),
        .out_free (out_free),
        .tokens   (tokens)
    );

endmodule

@@ hdl/ptf_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptf_chk
// port level checks of the tokenizer, bound to the top level
// ----------------------------------------------------------------------------
module ptf_chk import ptf_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [4:0]  symbol,
    input logic [30:0] number_value,
    input logic        run_last
);

    // one char at a time: ready drops right after an accept
    a_one_char: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("char accepted while previous char in flight");

    // an error token always closes the results of its char
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERR |-> run_last)
        else $error("error token not flagged run_last");

    // only number tokens carry a value
    a_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_NUM |-> number_value == '0)
        else $error("non number token with value");

    // stalled token holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(symbol)
            && $stable(number_value) && $stable(run_last))
        else $error("stalled token changed");

endmodule

bind paren_infix_to_postfix_tokenizer_top ptf_chk u_ptf_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (chars.valid),
    .in_ready     (chars.ready),
    .out_valid    (tokens.valid),
    .out_ready    (tokens.ready),
    .kind         (tokens.kind),
    .symbol       (tokens.symbol),
    .number_value (tokens.number_value),
    .run_last     (tokens.run_last)
);
